/* hw/rtl/ntpcv_pkg.sv */
// Package for the NTP seconds to civil date and time unit.
// Holds the epoch offset, the constant divisors with their reciprocals,
// the time-of-day bundle type and the March-based month start table.
`timescale 1ns / 1ps

package ntpcv_pkg;

	// Seconds from 1900-01-01 to 1970-01-01.
	localparam logic [31:0] NtpUnixOffset = 32'd2208988800;

	// Days per 400-year era and the era boundary of days since 1970.
	localparam logic [17:0] DaysPerEra = 18'd146097;
	// Days from 0000-03-01 to 1970-01-01, less four whole eras.
	localparam logic [17:0] DoeBias    = 18'd135080;
	localparam logic [17:0] EraLastDay = 18'd146096;
	localparam logic [17:0] DaysPerCent = 18'd36524;
	localparam logic [17:0] DaysPer4Yr = 18'd1460;
	localparam logic [17:0] DaysPerYr  = 18'd365;

	// Seconds per day is 2^7 times this.
	localparam int unsigned DaySlice  = 675;
	localparam int unsigned DayShift  = 25;
	localparam logic [15:0] DayRecip  = 16'((1 << DayShift) / DaySlice);

	// Seconds per hour is 2^4 times this.
	localparam int unsigned HourSlice = 225;
	localparam int unsigned HourShift = 13;
	localparam logic [5:0]  HourRecip = 6'((1 << HourShift) / HourSlice);

	// Seconds per minute is 2^2 times this.
	localparam int unsigned MinSlice  = 15;
	localparam int unsigned MinShift  = 10;
	localparam logic [6:0]  MinRecip  = 7'((1 << MinShift) / MinSlice);

	// Reciprocals for the era arithmetic on 18-bit day counts.
	localparam int unsigned EraShift  = 18;
	localparam logic [7:0]  Recip4Yr  = 8'((1 << EraShift) / 1460);
	localparam logic [9:0]  RecipYr   = 10'((1 << EraShift) / 365);

	// Century base years for the two eras that 32-bit time can reach.
	localparam logic [11:0] EraBaseLo = 12'd1600;
	localparam logic [11:0] EraBaseHi = 12'd2000;

	localparam int unsigned NumStages = 14;

	// Hour, minute and second of one result.
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	// Day of the March-based year on which month index mp starts.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] s;
		unique case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/ntp_seconds_to_civil_datetime_unit.sv */
// NTP seconds to civil date and time, fourteen-stage pipeline.
// Depends on ntpcv_pkg for constants, reciprocals, hms_t and month_start.
//
//   Channel | Direction | Contents
//   s_*     | in        | s_tdata[31:0] = ntp_seconds
//   m_*     | out       | m_tdata = year, month, day, hour, minute, second
//
// One transaction can enter every cycle unless every stage is full and m_tready is low.
// The depth is set by the chain of reciprocal multiplies, each followed by
// a registered remainder check, on the day count and the era arithmetic.
// Reset clears only the stage valid bits. A stage holds while its successor
// is full and stalled, so a bubble anywhere lets the input side keep going.
`timescale 1ns / 1ps

module ntp_seconds_to_civil_datetime_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] ntp_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] year, [15:12] month, [20:16] day, [25:21] hour,
	// [31:26] minute, [37:32] second, [39:38] zero
	output logic [39:0] m_tdata
);

	localparam int unsigned N = ntpcv_pkg::NumStages;

	logic [N:1] vld_q;
	logic [N:1] adv;

	// Stage enables: load on m_tready or when this or any later stage is empty.
	for (genvar i = 1; i <= N; i++) begin : g_adv
		assign adv[i] = m_tready || !(&vld_q[N:i]);
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[N];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= s_tvalid;
			end
			for (int i = 2; i <= N; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage registers.
	logic [31:0] unix_s1, unix_s2;
	logic [15:0] dq_s2, dq_s3, days_s4;
	logic [10:0] drem_s3;
	logic [6:0]  lo7_s3;
	logic [16:0] sod_s4, sod_s5;
	logic [4:0]  hq_s5, hq_s6, hour_s7, hour_s8, hour_s9;
	logic [8:0]  hrem_s6;
	logic [3:0]  lo4_s6;
	logic [11:0] remh_s7, remh_s8;
	logic [5:0]  mq_s8, mq_s9;
	logic [4:0]  mrem_s9;
	logic [1:0]  lo2_s9;
	ntpcv_pkg::hms_t hms_s10, hms_s11, hms_s12, hms_s13, hms_s14;

	logic [17:0] doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic        era5_s5, era5_s6, era5_s7, era5_s8, era5_s9, era5_s10;
	logic        era5_s11, era5_s12, era5_s13;
	logic [6:0]  q4_s6, q4_s7;
	logic [11:0] r4_s7;
	logic [2:0]  cent_s6, cent_s7;
	logic        end_s6, end_s7;
	logic [17:0] n_s8, n_s9;
	logic [8:0]  yq_s9, yq_s10;
	logic [9:0]  yr_s10;
	logic [8:0]  yoe_s11, yoe_s12, yoe_s13;
	logic [8:0]  doy_s12, doy_s13;
	logic [3:0]  mp_s13;
	logic [11:0] year_s14;
	logic [3:0]  month_s14;
	logic [4:0]  day_s14;

	// Combinational values between stages.
	logic [40:0] day_prod;
	logic [25:0] dmul, drem_full;
	logic        dcorr;
	logic [10:0] drem_fix;
	logic [18:0] hprod;
	logic [17:0] doe0;
	logic        era5;
	logic [12:0] hrem_full;
	logic [25:0] q4_prod;
	logic [2:0]  cent;
	logic        hcorr;
	logic [8:0]  hrem_fix;
	logic [17:0] r4_full;
	logic [16:0] mprod;
	logic [6:0]  q4_fix;
	logic [17:0] n_val;
	logic [9:0]  mrem_full;
	logic [27:0] yprod;
	logic        mcorr;
	logic [4:0]  mrem_fix;
	logic [17:0] yr_full;
	logic [1:0]  ycent;
	logic [17:0] ystart, doy_full;
	logic [3:0]  mp;
	logic [8:0]  d_full;
	logic [3:0]  mon;
	logic [11:0] base;

	always_comb begin
		// Day count: quotient estimate, then one remainder correction.
		day_prod  = 41'(unix_s1[31:7]) * 41'(ntpcv_pkg::DayRecip);
		dmul      = 26'(dq_s2) * 26'(ntpcv_pkg::DaySlice);
		drem_full = 26'(unix_s2[31:7]) - dmul;
		dcorr     = drem_s3 >= 11'(ntpcv_pkg::DaySlice);
		drem_fix  = dcorr ? drem_s3 - 11'(ntpcv_pkg::DaySlice) : drem_s3;

		// Hour of the day.
		hprod     = 19'(sod_s4[16:4]) * 19'(ntpcv_pkg::HourRecip);
		hrem_full = sod_s5[16:4] - 13'(hq_s5) * 13'(ntpcv_pkg::HourSlice);
		hcorr     = hrem_s6 >= 9'(ntpcv_pkg::HourSlice);
		hrem_fix  = hcorr ? hrem_s6 - 9'(ntpcv_pkg::HourSlice) : hrem_s6;

		// Minute and second.
		mprod     = 17'(remh_s7[11:2]) * 17'(ntpcv_pkg::MinRecip);
		mrem_full = remh_s8[11:2] - 10'(mq_s8) * 10'(ntpcv_pkg::MinSlice);
		mcorr     = mrem_s9 >= 5'(ntpcv_pkg::MinSlice);
		mrem_fix  = mcorr ? mrem_s9 - 5'(ntpcv_pkg::MinSlice) : mrem_s9;

		// Day of era; 32-bit time only reaches eras four and five.
		doe0 = 18'(days_s4) + ntpcv_pkg::DoeBias;
		era5 = doe0 >= ntpcv_pkg::DaysPerEra;

		// Leap-day corrections for the year of era.
		q4_prod = 26'(doe_s5) * 26'(ntpcv_pkg::Recip4Yr);
		cent    = 3'(doe_s5 >= ntpcv_pkg::DaysPerCent)
		        + 3'(doe_s5 >= 18'(2 * 36524))
		        + 3'(doe_s5 >= 18'(3 * 36524))
		        + 3'(doe_s5 >= ntpcv_pkg::EraLastDay);
		r4_full = doe_s6 - 18'(q4_s6) * ntpcv_pkg::DaysPer4Yr;
		q4_fix  = q4_s7 + 7'(r4_s7 >= 12'(ntpcv_pkg::DaysPer4Yr));
		n_val   = doe_s7 - 18'(q4_fix) + 18'(cent_s7) - 18'(end_s7);

		// Year of era.
		yprod   = 28'(n_s8) * 28'(ntpcv_pkg::RecipYr);
		yr_full = n_s9 - 18'(yq_s9) * ntpcv_pkg::DaysPerYr;

		// Day of the March-based year.
		ycent    = 2'(yoe_s11 >= 9'd100) + 2'(yoe_s11 >= 9'd200) + 2'(yoe_s11 >= 9'd300);
		ystart   = 18'(yoe_s11) * ntpcv_pkg::DaysPerYr + 18'(yoe_s11[8:2]) - 18'(ycent);
		doy_full = doe_s11 - ystart;

		// Month index from the month start table.
		mp = '0;
		for (int i = 1; i < 12; i++) begin
			mp = mp + 4'(doy_s12 >= ntpcv_pkg::month_start(4'(i)));
		end

		// Final calendar fields.
		d_full = doy_s13 - ntpcv_pkg::month_start(mp_s13) + 9'd1;
		mon    = (mp_s13 < 4'd10) ? mp_s13 + 4'd3 : mp_s13 - 4'd9;
		base   = era5_s13 ? ntpcv_pkg::EraBaseHi : ntpcv_pkg::EraBaseLo;
	end

	// Pipeline data; each stage loads under its own enable.
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			unix_s1 <= s_tdata - ntpcv_pkg::NtpUnixOffset;
		end
		if (adv[2]) begin
			unix_s2 <= unix_s1;
			dq_s2   <= day_prod[40:25];
		end
		if (adv[3]) begin
			dq_s3   <= dq_s2;
			drem_s3 <= drem_full[10:0];
			lo7_s3  <= unix_s2[6:0];
		end
		if (adv[4]) begin
			days_s4 <= dq_s3 + 16'(dcorr);
			sod_s4  <= {drem_fix[9:0], lo7_s3};
		end
		if (adv[5]) begin
			sod_s5  <= sod_s4;
			hq_s5   <= hprod[17:13];
			doe_s5  <= era5 ? doe0 - ntpcv_pkg::DaysPerEra : doe0;
			era5_s5 <= era5;
		end
		if (adv[6]) begin
			hq_s6   <= hq_s5;
			hrem_s6 <= hrem_full[8:0];
			lo4_s6  <= sod_s5[3:0];
			doe_s6  <= doe_s5;
			era5_s6 <= era5_s5;
			q4_s6   <= q4_prod[24:18];
			cent_s6 <= cent;
			end_s6  <= doe_s5 == ntpcv_pkg::EraLastDay;
		end
		if (adv[7]) begin
			hour_s7 <= hq_s6 + 5'(hcorr);
			remh_s7 <= {hrem_fix[7:0], lo4_s6};
			doe_s7  <= doe_s6;
			era5_s7 <= era5_s6;
			q4_s7   <= q4_s6;
			r4_s7   <= r4_full[11:0];
			cent_s7 <= cent_s6;
			end_s7  <= end_s6;
		end
		if (adv[8]) begin
			hour_s8 <= hour_s7;
			remh_s8 <= remh_s7;
			mq_s8   <= mprod[15:10];
			doe_s8  <= doe_s7;
			era5_s8 <= era5_s7;
			n_s8    <= n_val;
		end
		if (adv[9]) begin
			hour_s9 <= hour_s8;
			mq_s9   <= mq_s8;
			mrem_s9 <= mrem_full[4:0];
			lo2_s9  <= remh_s8[1:0];
			doe_s9  <= doe_s8;
			era5_s9 <= era5_s8;
			n_s9    <= n_s8;
			yq_s9   <= yprod[26:18];
		end
		if (adv[10]) begin
			hms_s10.hour   <= hour_s9;
			hms_s10.minute <= mq_s9 + 6'(mcorr);
			hms_s10.second <= {mrem_fix[3:0], lo2_s9};
			doe_s10        <= doe_s9;
			era5_s10       <= era5_s9;
			yq_s10         <= yq_s9;
			yr_s10         <= yr_full[9:0];
		end
		if (adv[11]) begin
			hms_s11  <= hms_s10;
			doe_s11  <= doe_s10;
			era5_s11 <= era5_s10;
			yoe_s11  <= yq_s10 + 9'(yr_s10 >= 10'(ntpcv_pkg::DaysPerYr));
		end
		if (adv[12]) begin
			hms_s12  <= hms_s11;
			era5_s12 <= era5_s11;
			yoe_s12  <= yoe_s11;
			doy_s12  <= doy_full[8:0];
		end
		if (adv[13]) begin
			hms_s13  <= hms_s12;
			era5_s13 <= era5_s12;
			yoe_s13  <= yoe_s12;
			doy_s13  <= doy_s12;
			mp_s13   <= mp;
		end
		if (adv[14]) begin
			hms_s14   <= hms_s13;
			day_s14   <= d_full[4:0];
			month_s14 <= mon;
			year_s14  <= 12'(yoe_s13) + base + 12'(mon <= 4'd2);
		end
	end

	assign m_tdata = {2'b00, hms_s14.second, hms_s14.minute, hms_s14.hour,
	                  day_s14, month_s14, year_s14};

endmodule
